@@ src/pvo_pkg.sv @@
// ----------------------------------------------------------------------------
// pvo_pkg
// Shared widths, types and axis selection codes for the polygon/voxel
// overlap test.
// ----------------------------------------------------------------------------
package pvo_pkg;

    // Fixed-point format of the inputs.
    localparam int VOXEL_BITS      = 10;
    localparam int COORD_FRAC_BITS = 8;
    localparam int COORD_FIELD     = 20;
    localparam int NORMAL_FIELD    = 16;

    // Derived datapath widths.
    localparam int CENTRE_W = VOXEL_BITS + COORD_FRAC_BITS;
    localparam int MUL_W    = (CENTRE_W + 1 > COORD_FIELD) ? CENTRE_W + 1 : COORD_FIELD;
    localparam int AXIS_W   = COORD_FIELD + 2;
    localparam int SABS_W   = AXIS_W + 2;
    localparam int PROD_W   = AXIS_W + MUL_W;
    localparam int DOT_W    = PROD_W + 2;
    localparam int BND_W    = DOT_W + 1;
    localparam int N_VERT   = 4;
    localparam int N_CELL   = 16;

    typedef logic signed [AXIS_W-1:0] t_axis;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic signed [BND_W-1:0]  t_bnd;
    typedef logic        [SABS_W-1:0] t_sabs;

    // One polygon/voxel pair as it travels down the row of cells.
    typedef struct packed {
        logic                                        hit;
        logic                                        quad;
        logic [2:0][CENTRE_W-1:0]                    centre;
        logic [N_VERT-1:0][2:0][COORD_FIELD-1:0]     vert;
        logic [2:0][NORMAL_FIELD-1:0]                normal;
    } t_word;

    // Which candidate axis a cell tests.
    typedef enum logic [1:0] {
        AX_UNIT,
        AX_EDGE,
        AX_NORMAL
    } t_axis_kind;

    typedef struct packed {
        t_axis_kind kind;
        logic [1:0] k;
        logic [1:0] j;
    } t_axis_sel;

endpackage

@@ src/pvo_cell.sv @@
// ----------------------------------------------------------------------------
// pvo_cell
// Tests one candidate axis against the word passing through and hands the
// word, with its hit flag updated, to the next cell.  Four internal stages:
// axis, products, dot products and bounds, interval compare.
// ----------------------------------------------------------------------------
module pvo_cell
    import pvo_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_axis_sel i_sel,
    input  logic      i_valid,
    input  t_word     i_word,
    output logic      o_adv,
    output logic      o_valid,
    output t_word     o_word,
    input  logic      i_adv
);

    // Stage registers.
    logic        r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    t_word       r_a_word, r_b_word, r_c_word, r_d_word;
    t_axis       r_a_axis [3];
    logic        r_a_used, r_b_used, r_c_used;
    t_prod       r_b_pv [N_VERT][3];
    t_prod       r_b_pc [3];
    t_sabs       r_b_sabs;
    t_bnd        r_c_dv [N_VERT];
    t_bnd        r_c_vhi, r_c_vlo;

    logic        en_a, en_b, en_c, en_d;

    t_axis       n_axis [3];
    logic        n_used;
    logic [1:0]  nx;
    logic signed [COORD_FIELD:0] edge_v [3];
    t_prod       n_pv [N_VERT][3];
    t_prod       n_pc [3];
    t_sabs       n_sabs;
    t_dot        n_dv [N_VERT];
    t_dot        n_dc;
    t_dot        half_span;
    t_bnd        plo, phi;
    logic        sep;
    t_word       n_word;

    // A stage loads when it is empty or its content moves on.
    assign en_d  = !r_d_valid || i_adv;
    assign en_c  = !r_c_valid || en_d;
    assign en_b  = !r_b_valid || en_c;
    assign en_a  = !r_a_valid || en_b;
    assign o_adv = en_a;

    // Axis from the incoming word: edge end wraps to the first vertex.
    always_comb begin
        if (i_sel.j == 2'd2 && !i_word.quad) begin
            nx = 2'd0;
        end else begin
            nx = i_sel.j + 2'd1;
        end
        for (int c = 0; c < 3; c++) begin
            edge_v[c] = (COORD_FIELD+1)'($signed(i_word.vert[nx][c]))
                      - (COORD_FIELD+1)'($signed(i_word.vert[i_sel.j][c]));
            n_axis[c] = '0;
        end
        n_used = !(i_sel.kind == AX_EDGE && i_sel.j == 2'd3 && !i_word.quad);
        case (i_sel.kind)
            AX_UNIT: begin
                case (i_sel.k)
                    2'd0:    n_axis[0] = AXIS_W'(1);
                    2'd1:    n_axis[1] = AXIS_W'(1);
                    default: n_axis[2] = AXIS_W'(1);
                endcase
            end
            AX_EDGE: begin
                case (i_sel.k)
                    2'd0: begin
                        n_axis[1] = -AXIS_W'(edge_v[2]);
                        n_axis[2] = AXIS_W'(edge_v[1]);
                    end
                    2'd1: begin
                        n_axis[0] = AXIS_W'(edge_v[2]);
                        n_axis[2] = -AXIS_W'(edge_v[0]);
                    end
                    default: begin
                        n_axis[0] = -AXIS_W'(edge_v[1]);
                        n_axis[1] = AXIS_W'(edge_v[0]);
                    end
                endcase
            end
            default: begin
                for (int c = 0; c < 3; c++) begin
                    n_axis[c] = AXIS_W'($signed(i_word.normal[c]));
                end
            end
        endcase
    end

    // Stage A holds the axis.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en_a) begin
            r_a_valid <= i_valid;
        end
        if (en_a) begin
            r_a_word <= i_word;
            r_a_used <= n_used;
            r_a_axis <= n_axis;
        end
    end

    // Products of the axis with every vertex and with the voxel centre.
    always_comb begin
        n_sabs = '0;
        for (int c = 0; c < 3; c++) begin
            for (int v = 0; v < N_VERT; v++) begin
                n_pv[v][c] = PROD_W'(r_a_axis[c])
                           * PROD_W'($signed(r_a_word.vert[v][c]));
            end
            n_pc[c] = PROD_W'(r_a_axis[c])
                    * PROD_W'($signed({1'b0, r_a_word.centre[c]}));
            if (r_a_axis[c] < 0) begin
                n_sabs = n_sabs + SABS_W'(-r_a_axis[c]);
            end else begin
                n_sabs = n_sabs + SABS_W'(r_a_axis[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en_b) begin
            r_b_valid <= r_a_valid;
        end
        if (en_b) begin
            r_b_word <= r_a_word;
            r_b_used <= r_a_used;
            r_b_pv   <= n_pv;
            r_b_pc   <= n_pc;
            r_b_sabs <= n_sabs;
        end
    end

    // Dot products and the voxel interval around the centre projection.
    always_comb begin
        for (int v = 0; v < N_VERT; v++) begin
            n_dv[v] = DOT_W'(r_b_pv[v][0]) + DOT_W'(r_b_pv[v][1])
                    + DOT_W'(r_b_pv[v][2]);
        end
        n_dc      = DOT_W'(r_b_pc[0]) + DOT_W'(r_b_pc[1]) + DOT_W'(r_b_pc[2]);
        half_span = $signed(DOT_W'(r_b_sabs) << (COORD_FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en_c) begin
            r_c_valid <= r_b_valid;
        end
        if (en_c) begin
            r_c_word <= r_b_word;
            r_c_used <= r_b_used;
            for (int v = 0; v < N_VERT; v++) begin
                r_c_dv[v] <= BND_W'(n_dv[v]);
            end
            r_c_vhi <= BND_W'(n_dc) + BND_W'(half_span);
            r_c_vlo <= BND_W'(n_dc) - BND_W'(half_span);
        end
    end

    // Polygon interval and the strict separation compare.
    always_comb begin
        plo = r_c_dv[0];
        phi = r_c_dv[0];
        for (int v = 1; v < N_VERT; v++) begin
            if (v < 3 || r_c_word.quad) begin
                if (r_c_dv[v] < plo) begin
                    plo = r_c_dv[v];
                end
                if (r_c_dv[v] > phi) begin
                    phi = r_c_dv[v];
                end
            end
        end
        sep        = r_c_used && ((plo > r_c_vhi) || (r_c_vlo > phi));
        n_word     = r_c_word;
        n_word.hit = r_c_word.hit && !sep;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en_d) begin
            r_d_valid <= r_c_valid;
        end
        if (en_d) begin
            r_d_word <= n_word;
        end
    end

    assign o_valid = r_d_valid;
    assign o_word  = r_d_word;

endmodule

@@ src/polygon_voxel_overlap_test.sv @@
// ----------------------------------------------------------------------------
// polygon_voxel_overlap_test
// Separating axis overlap test of a unit voxel against a triangle or quad.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Word
// in        input      i_valid / o_stall   voxel index, four vertices, normal,
//                                          quad flag
// out       output     o_valid / i_stall   overlap flag
//
// Sixteen cells in a row each test one axis; every cell has four stages.
// One word is accepted per cycle while o_stall is low.
// Reset clears only the stage valid bits; no state survives between words.
// A stall holds the last stage; earlier stages keep filling empty slots
// until the whole row is occupied, and only then is o_stall raised.
// ----------------------------------------------------------------------------
module polygon_voxel_overlap_test
    import pvo_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [9:0]   i_voxel_x,
    input  logic [9:0]   i_voxel_y,
    input  logic [9:0]   i_voxel_z,
    input  logic [59:0]  i_vertex_a,
    input  logic [59:0]  i_vertex_b,
    input  logic [59:0]  i_vertex_c,
    input  logic [59:0]  i_vertex_d,
    input  logic [47:0]  i_plane_normal,
    input  logic         i_is_quad,
    output logic         o_valid,
    output logic         o_overlaps,
    input  logic         i_stall
);

    t_word in_word;
    t_word words  [N_CELL+1];
    logic  valids [N_CELL+1];
    logic  advs   [N_CELL+1];

    // Build the incoming word: centres scaled into the coordinate format.
    always_comb begin
        in_word.hit       = 1'b1;
        in_word.quad      = i_is_quad;
        in_word.centre[0] = CENTRE_W'(i_voxel_x[VOXEL_BITS-1:0]) << COORD_FRAC_BITS;
        in_word.centre[1] = CENTRE_W'(i_voxel_y[VOXEL_BITS-1:0]) << COORD_FRAC_BITS;
        in_word.centre[2] = CENTRE_W'(i_voxel_z[VOXEL_BITS-1:0]) << COORD_FRAC_BITS;
        in_word.vert[0]   = i_vertex_a;
        in_word.vert[1]   = i_vertex_b;
        in_word.vert[2]   = i_vertex_c;
        in_word.vert[3]   = i_vertex_d;
        in_word.normal    = i_plane_normal;
    end

    assign words[0]       = in_word;
    assign valids[0]      = i_valid;
    assign advs[N_CELL]   = !i_stall;

    // Per coordinate axis: the axis itself, then its cross with each edge.
    for (genvar k = 0; k < 3; k++) begin : g_axis
        for (genvar j = 0; j < 5; j++) begin : g_test
            localparam int C = k * 5 + j;
            t_axis_sel sel;
            always_comb begin
                sel.kind = (j == 0) ? AX_UNIT : AX_EDGE;
                sel.k    = 2'(k);
                sel.j    = (j == 0) ? 2'd0 : 2'(j - 1);
            end
            pvo_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_sel   (sel),
                .i_valid (valids[C]),
                .i_word  (words[C]),
                .o_adv   (advs[C]),
                .o_valid (valids[C+1]),
                .o_word  (words[C+1]),
                .i_adv   (advs[C+1])
            );
        end
    end

    // The polygon normal is tested in the last cell.
    t_axis_sel normal_sel;
    always_comb begin
        normal_sel.kind = AX_NORMAL;
        normal_sel.k    = 2'd0;
        normal_sel.j    = 2'd0;
    end

    pvo_cell u_normal_cell (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sel   (normal_sel),
        .i_valid (valids[N_CELL-1]),
        .i_word  (words[N_CELL-1]),
        .o_adv   (advs[N_CELL-1]),
        .o_valid (valids[N_CELL]),
        .o_word  (words[N_CELL]),
        .i_adv   (advs[N_CELL])
    );

    assign o_stall    = !advs[0];
    assign o_valid    = valids[N_CELL];
    assign o_overlaps = words[N_CELL].hit;

    // The row can only be full when a result is waiting at the output.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result waiting");

    // An output that is taken frees the whole row for a new word.
    a_flow_when_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output flows");

    // A word accepted into the first cell shows up there on the next edge.
    a_first_stage_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> g_axis[0].g_test[0].u_cell.r_a_valid)
        else $error("accepted word lost at the first cell");

endmodule

@@ verif/overlap_checker.sv @@
// ----------------------------------------------------------------------------
// overlap_checker
// Watches both channels of the polygon/voxel overlap block, computes the
// expected overlap flag of every accepted word and compares it with the
// flag that comes out, in order.
// ----------------------------------------------------------------------------
module overlap_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [9:0]  i_voxel_x,
    input  logic [9:0]  i_voxel_y,
    input  logic [9:0]  i_voxel_z,
    input  logic [59:0] i_vertex_a,
    input  logic [59:0] i_vertex_b,
    input  logic [59:0] i_vertex_c,
    input  logic [59:0] i_vertex_d,
    input  logic [47:0] i_plane_normal,
    input  logic        i_is_quad,
    input  logic        i_out_valid,
    input  logic        i_overlaps,
    input  logic        i_out_stall,
    output int          o_errors,
    output int          o_pending,
    output int          o_hits,
    output int          o_misses
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint signed t_vec [3];

    bit overlap_flags [$];

    function automatic longint signed dot_with(t_vec a, t_vec b);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // True when the axis puts the polygon strictly apart from the voxel.
    function automatic bit axis_apart(t_vec ax, t_vec ctr, t_vec vt [4], int nv);
        longint signed vlo, vhi, plo, phi, p;
        t_vec cor;
        for (int i = 0; i < 8; i++) begin
            cor[0] = ctr[0] + ((i & 4) ? 128 : -128);
            cor[1] = ctr[1] + ((i & 2) ? 128 : -128);
            cor[2] = ctr[2] + ((i & 1) ? 128 : -128);
            p = dot_with(ax, cor);
            if (i == 0 || p < vlo) vlo = p;
            if (i == 0 || p > vhi) vhi = p;
        end
        for (int i = 0; i < nv; i++) begin
            p = dot_with(ax, vt[i]);
            if (i == 0 || p < plo) plo = p;
            if (i == 0 || p > phi) phi = p;
        end
        return (plo > vhi) || (vlo > phi);
    endfunction

    // Separating axis test over unit axes, edge crosses and the normal.
    function automatic bit predict_overlap(logic [9:0] vx, logic [9:0] vy,
                                           logic [9:0] vz, logic [59:0] va,
                                           logic [59:0] vb, logic [59:0] vc,
                                           logic [59:0] vd, logic [47:0] nrm,
                                           logic quad);
        t_vec ctr, nv3, ax, e;
        t_vec vt [4];
        logic [59:0] raw [4];
        int nv, nx;
        raw[0] = va; raw[1] = vb; raw[2] = vc; raw[3] = vd;
        nv = quad ? 4 : 3;
        ctr[0] = longint'(vx) * 256;
        ctr[1] = longint'(vy) * 256;
        ctr[2] = longint'(vz) * 256;
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 3; i++)
                vt[j][i] = longint'($signed(raw[j][20*i +: 20]));
        for (int i = 0; i < 3; i++)
            nv3[i] = longint'($signed(nrm[16*i +: 16]));
        for (int k = 0; k < 3; k++) begin
            ax = '{0, 0, 0};
            ax[k] = 1;
            if (axis_apart(ax, ctr, vt, nv)) return 1'b0;
            for (int j = 0; j < nv; j++) begin
                nx = (j + 1 < nv) ? j + 1 : 0;
                for (int i = 0; i < 3; i++) e[i] = vt[nx][i] - vt[j][i];
                case (k)
                    0: ax = '{0, -e[2], e[1]};
                    1: ax = '{e[2], 0, -e[0]};
                    default: ax = '{-e[1], e[0], 0};
                endcase
                if (axis_apart(ax, ctr, vt, nv)) return 1'b0;
            end
        end
        return !axis_apart(nv3, ctr, vt, nv);
    endfunction

    // Predict on every accepted input word, compare on every output word.
    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            o_errors = 0;
            o_hits = 0;
            o_misses = 0;
        end else begin
            if (i_valid && !i_in_stall)
                overlap_flags = {overlap_flags, predict_overlap(i_voxel_x, i_voxel_y,
                    i_voxel_z, i_vertex_a, i_vertex_b, i_vertex_c, i_vertex_d,
                    i_plane_normal, i_is_quad)};
            if (i_out_valid && !i_out_stall) begin
                if (overlap_flags.size() == 0) begin
                    $display("%t: unexpected word, expected none, actual overlaps=%b",
                             $realtime, i_overlaps);
                    o_errors++;
                end else begin
                    want = overlap_flags.pop_front();
                    if (want) o_hits++; else o_misses++;
                    if (i_overlaps !== want) begin
                        $display("%t: overlaps mismatch, expected %b, actual %b",
                                 $realtime, want, i_overlaps);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = overlap_flags.size();
    end
endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives voxel/polygon pairs into the overlap block with random gaps and
// output stalls, including one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [9:0]  vox_x = '0, vox_y = '0, vox_z = '0;
    logic [59:0] vert_a = '0, vert_b = '0, vert_c = '0, vert_d = '0;
    logic [47:0] normal = '0;
    logic        quad = 1'b0;
    logic        out_valid, overlap_flag;
    logic        out_stall = 1'b0;
    int          errors, pending, hits, misses;
    int          sender_idle = 0;
    int          receiver_idle = 0;
    bit          hold_off = 1'b0;
    int          sent = 0;

    always #5 clk = ~clk;

    polygon_voxel_overlap_test DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_voxel_x(vox_x), .i_voxel_y(vox_y), .i_voxel_z(vox_z),
        .i_vertex_a(vert_a), .i_vertex_b(vert_b), .i_vertex_c(vert_c),
        .i_vertex_d(vert_d), .i_plane_normal(normal), .i_is_quad(quad),
        .o_valid(out_valid), .o_overlaps(overlap_flag), .i_stall(out_stall)
    );

    overlap_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_in_stall(in_stall),
        .i_voxel_x(vox_x), .i_voxel_y(vox_y), .i_voxel_z(vox_z),
        .i_vertex_a(vert_a), .i_vertex_b(vert_b), .i_vertex_c(vert_c),
        .i_vertex_d(vert_d), .i_plane_normal(normal), .i_is_quad(quad),
        .i_out_valid(out_valid), .i_overlaps(overlap_flag),
        .i_out_stall(out_stall), .o_errors(errors), .o_pending(pending),
        .o_hits(hits), .o_misses(misses)
    );

    function automatic logic [59:0] pack_vertex(int x, int y, int z);
        logic [19:0] px = 20'(x), py = 20'(y), pz = 20'(z);
        return {pz, py, px};
    endfunction

    // A vertex near the voxel centre, offset by up to span in Q11.8 units.
    function automatic logic [59:0] near_vertex(logic [9:0] vx, logic [9:0] vy,
                                                logic [9:0] vz, int span);
        return pack_vertex(int'(vx) * 256 + int'($urandom_range(2 * span)) - span,
                           int'(vy) * 256 + int'($urandom_range(2 * span)) - span,
                           int'(vz) * 256 + int'($urandom_range(2 * span)) - span);
    endfunction

    // Receiver stalls at random, or holds off completely when asked.
    always @(negedge clk) begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (receiver_idle > 0) && ($urandom_range(99) < receiver_idle);
    end

    // Present one word and wait until it is accepted.
    task automatic send_word(logic [9:0] vx, logic [9:0] vy, logic [9:0] vz,
                             logic [59:0] va, logic [59:0] vb, logic [59:0] vc,
                             logic [59:0] vd, logic [47:0] nrm, logic q);
        while ((sender_idle > 0) && ($urandom_range(99) < sender_idle)) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        vox_x <= vx; vox_y <= vy; vox_z <= vz;
        vert_a <= va; vert_b <= vb; vert_c <= vc; vert_d <= vd;
        normal <= nrm; quad <= q;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Random word: mostly a polygon near the voxel, sometimes raw noise.
    task automatic send_random();
        logic [9:0] vx, vy, vz;
        int span;
        vx = 10'($urandom); vy = 10'($urandom); vz = 10'($urandom);
        if ($urandom_range(9) == 0) begin
            send_word(vx, vy, vz, 60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                      60'({$urandom, $urandom}), 60'({$urandom, $urandom}),
                      48'({$urandom, $urandom}), 1'($urandom));
        end else begin
            span = ($urandom_range(3) == 0) ? 2000 : int'($urandom_range(64, 400));
            send_word(vx, vy, vz, near_vertex(vx, vy, vz, span),
                      near_vertex(vx, vy, vz, span), near_vertex(vx, vy, vz, span),
                      near_vertex(vx, vy, vz, span),
                      {16'($urandom), 16'($urandom), 16'($urandom)}, 1'($urandom));
        end
    endtask

    // Long output hold-off, counted in its own process.
    initial begin
        wait (sent >= 400);
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        int c;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed words: extremes, touching faces, degenerate axes.
        send_word(10'd0, 10'd0, 10'd0, '0, '0, '0, '0, '0, 1'b0);
        send_word(10'd1023, 10'd1023, 10'd1023, '1, '1, '1, '1, '1, 1'b1);
        send_word(10'd5, 10'd5, 10'd5, pack_vertex(1408, 0, 0),
                  pack_vertex(1408, 5000, 0), pack_vertex(1408, 0, 5000),
                  '0, {16'd0, 16'd0, 16'h4000}, 1'b0);
        send_word(10'd5, 10'd5, 10'd5, pack_vertex(1409, 0, 0),
                  pack_vertex(1409, 5000, 0), pack_vertex(1409, 0, 5000),
                  '0, {16'd0, 16'd0, 16'h4000}, 1'b0);
        send_word(10'd5, 10'd5, 10'd5, pack_vertex(1280, 1280, 1280),
                  pack_vertex(1280, 1280, 1280), pack_vertex(1280, 1280, 1280),
                  pack_vertex(99999, 0, 0), '0, 1'b0);
        send_word(10'd2, 10'd3, 10'd4, pack_vertex(300, 700, 900),
                  pack_vertex(700, 700, 1100), pack_vertex(700, 900, 1100),
                  pack_vertex(300, 900, 900), {16'h7fff, 16'h8000, 16'h0001}, 1'b1);
        send_word(10'd2, 10'd3, 10'd4, pack_vertex(-524288, 524287, -524288),
                  pack_vertex(524287, -524288, 524287), pack_vertex(0, 0, 0),
                  pack_vertex(524287, 524287, 524287), {16'h8000, 16'h8000, 16'h8000},
                  1'b1);
        send_word(10'd512, 10'd256, 10'd128, pack_vertex(131072, 65536, 32768),
                  pack_vertex(131200, 65536, 32768), pack_vertex(131072, 65664, 32900),
                  '1, {16'h0000, 16'h2000, 16'hc000}, 1'b0);

        // Random phases with different idling mixes.
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 61 : 27) : 0;
            receiver_idle = (ph == 2) ? 61 : ((ph == 3) ? 27 : 0);
            for (c = 0; c < 325; c++) send_random();
        end
        in_valid <= 1'b0;
        sender_idle = 0;
        receiver_idle = 0;

        wait (pending == 0);
        repeat (80) @(posedge clk);
        $display("Sent %0d pairs; %0d overlapped, %0d were separated.",
                 sent, hits, misses);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
src/pvo_pkg.sv
src/pvo_cell.sv
src/polygon_voxel_overlap_test.sv
verif/overlap_checker.sv
verif/testbench.sv
